// ===== rtl/mcetb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcetb_pkg - shared types and constants for the event timer bank
// Command and result codes, slot states and controller command bundle.
// ----------------------------------------------------------------------------
package mcetb_pkg;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_ADJUST   = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_DEADLINE = 3'd3;
    localparam logic [2:0] CMD_ADVANCE  = 3'd4;
    localparam logic [2:0] CMD_ELAPSED  = 3'd5;

    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    localparam logic [1:0] ST_INACTIVE = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_DEFERRED = 2'd2;

    localparam logic signed [31:0] NEVER_TICKS = 32'sh7FFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item, reset scan
        logic step;      // process the scan slot
        logic finish;    // end of scan: promote deferred, build final result
        logic single;    // build single-result answer for non-scan commands
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_cmd;  // captured command walks the slots
        logic scan_end;  // scan index at last slot
        logic fire;      // current step produced a fire result
    } dp_stat_t;

endpackage

// ===== rtl/mcetb_datapath.sv =====
// ----------------------------------------------------------------------------
// mcetb_datapath - timer storage and arithmetic
// Holds per-slot state, scans slots one per cycle while step is high, forms results.
// ----------------------------------------------------------------------------
module mcetb_datapath #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcetb_pkg::dp_cmd_t   cmd,
    output mcetb_pkg::dp_stat_t  stat,
    input  logic [2:0]           in_cmd,
    input  logic [3:0]           in_slot,
    input  logic                 in_loop,
    input  logic                 in_deferred,
    input  logic [30:0]          in_period,
    input  logic [30:0]          in_first_delay,
    input  logic [30:0]          in_cpu_offset,
    input  logic signed [31:0]   in_refcon,
    input  logic [30:0]          in_amount,
    output logic [1:0]           res_kind,
    output logic [3:0]           res_slot,
    output logic signed [31:0]   res_refcon,
    output logic signed [31:0]   res_value,
    output logic                 res_last
);
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [1:0]         state_reg [NUM_TIMERS];
    logic               per_reg   [NUM_TIMERS];
    logic signed [31:0] rem_mem   [NUM_TIMERS];
    logic signed [31:0] rld_reg   [NUM_TIMERS];
    logic signed [31:0] tag_mem   [NUM_TIMERS];

    logic [2:0]         cmd_reg;
    logic [30:0]        amt_reg;
    logic signed [31:0] best_reg;
    logic [IW-1:0]      idx_reg;
    logic               fired_reg;

    logic               in_range;
    logic [IW-1:0]      sidx;
    logic               found;
    logic [IW-1:0]      free_idx;
    logic [31:0]        sum_add;
    logic [31:0]        sum_adj;
    logic signed [31:0] rem_add;
    logic signed [31:0] rem_adj;
    logic signed [32:0] dec_wide;
    logic signed [31:0] dec;
    logic               live;
    logic               expire;
    logic signed [31:0] new_rld;
    logic signed [32:0] el_wide;
    logic signed [31:0] el;

    assign in_range = ({28'd0, in_slot} < 32'(NUM_TIMERS));
    assign sidx     = IW'(in_slot);

    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (state_reg[i] == mcetb_pkg::ST_INACTIVE)
            begin
                found    = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign sum_add = {1'b0, in_period} + {1'b0, in_cpu_offset};
    assign sum_adj = {1'b0, in_first_delay} + {1'b0, in_cpu_offset};
    assign rem_add = sum_add[31] ? mcetb_pkg::NEVER_TICKS : $signed(sum_add);
    assign rem_adj = sum_adj[31] ? mcetb_pkg::NEVER_TICKS : $signed(sum_adj);

    assign live = (state_reg[idx_reg] == mcetb_pkg::ST_ACTIVE) &&
                  (rem_mem[idx_reg] != mcetb_pkg::NEVER_TICKS);
    assign dec_wide = {rem_mem[idx_reg][31], rem_mem[idx_reg]} - $signed({2'b00, amt_reg});
    assign dec = (dec_wide[32] != dec_wide[31]) ? 32'sh8000_0000 : dec_wide[31:0];
    assign expire = (cmd_reg == mcetb_pkg::CMD_ADVANCE) && live && (dec <= 0);
    assign new_rld = (rld_reg[idx_reg] <= 0) ? mcetb_pkg::NEVER_TICKS : rld_reg[idx_reg];

    assign el_wide = {rld_reg[sidx][31], rld_reg[sidx]} - {rem_mem[sidx][31], rem_mem[sidx]};
    assign el = (el_wide[32] != el_wide[31]) ?
                (el_wide[32] ? 32'sh8000_0000 : mcetb_pkg::NEVER_TICKS) : el_wide[31:0];

    assign stat.scan_cmd = (cmd_reg == mcetb_pkg::CMD_ADVANCE) ||
                           (cmd_reg == mcetb_pkg::CMD_DEADLINE);
    assign stat.scan_end = (32'(idx_reg) == NUM_TIMERS - 1);
    assign stat.fire     = expire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                state_reg[i] <= mcetb_pkg::ST_INACTIVE;
                per_reg[i]   <= 1'b0;
                rld_reg[i]   <= '0;
            end
            cmd_reg   <= '0;
            idx_reg   <= '0;
            fired_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cmd_reg   <= in_cmd;
                idx_reg   <= '0;
                fired_reg <= 1'b0;
                case (in_cmd)
                    mcetb_pkg::CMD_ADD:
                    begin
                        if (found)
                        begin
                            state_reg[free_idx] <= in_deferred ? mcetb_pkg::ST_DEFERRED
                                                               : mcetb_pkg::ST_ACTIVE;
                            per_reg[free_idx] <= in_loop;
                            rld_reg[free_idx] <= {1'b0, in_period};
                        end
                    end
                    mcetb_pkg::CMD_ADJUST:
                    begin
                        if (in_range)
                            rld_reg[sidx] <= {1'b0, in_period};
                    end
                    mcetb_pkg::CMD_REMOVE:
                    begin
                        if (in_range)
                            state_reg[sidx] <= mcetb_pkg::ST_INACTIVE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.step)
            begin
                if (expire)
                begin
                    fired_reg <= 1'b1;
                    if (!per_reg[idx_reg])
                        state_reg[idx_reg] <= mcetb_pkg::ST_INACTIVE;
                    else
                        rld_reg[idx_reg] <= new_rld;
                end
                if (!stat.scan_end)
                    idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.finish && (cmd_reg == mcetb_pkg::CMD_ADVANCE))
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                    if (state_reg[i] == mcetb_pkg::ST_DEFERRED)
                        state_reg[i] <= mcetb_pkg::ST_ACTIVE;
            end
        end
    end

    // payload storage and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            amt_reg  <= in_amount;
            best_reg <= {1'b0, in_amount};
            case (in_cmd)
                mcetb_pkg::CMD_ADD:
                begin
                    if (found)
                    begin
                        rem_mem[free_idx] <= rem_add;
                        tag_mem[free_idx] <= in_refcon;
                    end
                end
                mcetb_pkg::CMD_ADJUST:
                begin
                    if (in_range)
                    begin
                        rem_mem[sidx] <= rem_adj;
                        tag_mem[sidx] <= in_refcon;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.single)
        begin
            res_refcon <= '0;
            res_last   <= 1'b1;
            case (in_cmd)
                mcetb_pkg::CMD_ADD:
                begin
                    res_kind  <= found ? mcetb_pkg::KIND_DONE : mcetb_pkg::KIND_FULL;
                    res_slot  <= found ? 4'(free_idx) : 4'd0;
                    res_value <= '0;
                end
                mcetb_pkg::CMD_ELAPSED:
                begin
                    res_kind  <= mcetb_pkg::KIND_DONE;
                    res_slot  <= in_slot;
                    res_value <= in_range ? el : 32'sd0;
                end
                mcetb_pkg::CMD_ADJUST, mcetb_pkg::CMD_REMOVE:
                begin
                    res_kind  <= mcetb_pkg::KIND_DONE;
                    res_slot  <= in_slot;
                    res_value <= '0;
                end
                default:
                begin
                    res_kind  <= mcetb_pkg::KIND_DONE;
                    res_slot  <= 4'd0;
                    res_value <= '0;
                end
            endcase
        end
        if (cmd.step)
        begin
            if (cmd_reg == mcetb_pkg::CMD_DEADLINE)
            begin
                if ((state_reg[idx_reg] != mcetb_pkg::ST_INACTIVE) &&
                    (rem_mem[idx_reg] < best_reg))
                    best_reg <= rem_mem[idx_reg];
            end
            else if (live)
            begin
                if (expire && per_reg[idx_reg])
                    rem_mem[idx_reg] <= new_rld;
                else
                    rem_mem[idx_reg] <= dec;
            end
            if (expire)
            begin
                res_kind   <= mcetb_pkg::KIND_FIRE;
                res_slot   <= 4'(idx_reg);
                res_refcon <= tag_mem[idx_reg];
                res_value  <= '0;
                res_last   <= 1'b0;
            end
        end
        // keep a waiting fire item; only a walk with no fire ends in a done item
        if (cmd.finish && !fired_reg)
        begin
            res_kind   <= mcetb_pkg::KIND_DONE;
            res_slot   <= '0;
            res_refcon <= '0;
            res_value  <= (cmd_reg == mcetb_pkg::CMD_DEADLINE) ? best_reg : 32'sd0;
            res_last   <= 1'b1;
        end
    end

endmodule

// ===== rtl/mcetb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcetb_ctrl - command sequencer
// Accepts items, steps the slot scan and hands results to the output port.
// ----------------------------------------------------------------------------
module mcetb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 in_scan,
    output logic                 res_last_fix,
    output mcetb_pkg::dp_cmd_t   cmd,
    input  mcetb_pkg::dp_stat_t  stat
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_HOLD  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       pend_reg, pend_next;   // a fire item waits in the result register

    // the item shown from S_OUT is always the final one of its command
    assign res_last_fix = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.single = !in_scan;
                    pend_next  = 1'b0;
                    state_next = in_scan ? S_SCAN : S_OUT;
                end
            end
            S_SCAN:
            begin
                // hold the walk and release the waiting fire before the next one
                if (stat.fire && pend_reg)
                    state_next = S_HOLD;
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.fire)
                        pend_next = 1'b1;
                    if (stat.scan_end)
                        state_next = S_FIN;
                end
            end
            S_HOLD:
            begin
                m_valid = 1'b1;
                if (m_ready)
                begin
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_valid = 1'b1;
                if (m_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end
endmodule

// ===== rtl/multi_channel_event_timer_bank.sv =====
// ----------------------------------------------------------------------------
// multi_channel_event_timer_bank - bank of one-shot and periodic timers
// Sequencer plus slot datapath behind stream ports.
// ----------------------------------------------------------------------------
// Usage: each input item carries one command (add, adjust, remove, next
// deadline, advance, elapsed) on s_tdata. Results leave on m_tdata with
// m_tuser = kind and m_tlast marking the final result of the command.
// Add, adjust, remove and elapsed answer in the cycle after acceptance. Next
// deadline and advance walk the NUM_TIMERS slots one per cycle through the
// shared subtract/compare unit, save while a waiting fire is held on the
// output, then a finishing step forms the final result. A fire waits in the
// result register until the walk finds the next fire or ends, so the last
// fire carries m_tlast and no closing item follows; an advance with no fire
// answers with one done item. Reset clears all slots to inactive. A stall on
// m_tready holds the result and the walk; s_tready stays low until the
// command is done.
// ----------------------------------------------------------------------------
module multi_channel_event_timer_bank #(
    parameter int NUM_TIMERS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[2:0] slot[6:3] loop[7] deferred[8] period[39:9] first_delay[70:40]
    // cpu_offset[101:71] refcon[133:102] amount[164:134]
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_slot[3:0] out_refcon[35:4] value[67:36]
    output logic [71:0]  m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    mcetb_pkg::dp_cmd_t  cmd;
    mcetb_pkg::dp_stat_t stat;
    logic [3:0]          r_slot;
    logic signed [31:0]  r_refcon, r_value;
    logic                r_last, fix;
    logic                in_scan;

    assign in_scan = (s_tdata[2:0] == mcetb_pkg::CMD_ADVANCE) ||
                     (s_tdata[2:0] == mcetb_pkg::CMD_DEADLINE);

    mcetb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .in_scan(in_scan), .res_last_fix(fix),
        .cmd(cmd), .stat(stat)
    );

    mcetb_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_cmd(s_tdata[2:0]), .in_slot(s_tdata[6:3]),
        .in_loop(s_tdata[7]), .in_deferred(s_tdata[8]),
        .in_period(s_tdata[39:9]), .in_first_delay(s_tdata[70:40]),
        .in_cpu_offset(s_tdata[101:71]), .in_refcon(s_tdata[133:102]),
        .in_amount(s_tdata[164:134]),
        .res_kind(m_tuser), .res_slot(r_slot), .res_refcon(r_refcon),
        .res_value(r_value), .res_last(r_last)
    );

    assign m_tdata = {4'd0, r_value, r_refcon, r_slot};
    assign m_tlast = r_last | fix;
endmodule

// ===== test/multi_channel_event_timer_bank_tb.sv =====
// ----------------------------------------------------------------------------
// multi_channel_event_timer_bank_tb - self-checking bench for the timer bank
// Drives add, adjust, remove, deadline, advance and elapsed items with random
// gaps on both streams, predicts every result from a local model of the slot
// table and checks each result field by field in order.
// ----------------------------------------------------------------------------
module multi_channel_event_timer_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int FIRE_CAP = 16;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         slot;
        logic signed [31:0] refc;
        logic signed [31:0] val;
        logic               last;
    } timer_result_t;

    typedef struct {
        logic [2:0]         cmd;
        logic [3:0]         slot;
        logic               loop;
        logic               deferred;
        logic [30:0]        period;
        logic [30:0]        first_delay;
        logic [30:0]        cpu_offset;
        logic signed [31:0] refcon;
        logic [30:0]        amount;
    } timer_cmd_t;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return mcetb_pkg::NEVER_TICKS;
        if (v < -64'sd2147483648)
            return INT_MIN;
        return v[31:0];
    endfunction

    class timer_scoreboard;
        logic [1:0]         st_q[SLOTS];
        logic               per_q[SLOTS];
        logic signed [31:0] rem_q[SLOTS];
        logic signed [31:0] rld_q[SLOTS];
        logic signed [31:0] tag_q[SLOTS];
        bit                 rem_set[SLOTS];
        timer_result_t      pending[$];
        int                 errors;

        function void clear();
            for (int i = 0; i < SLOTS; i++)
            begin
                st_q[i] = mcetb_pkg::ST_INACTIVE;
                per_q[i] = 1'b0;
                rem_q[i] = '0;
                rld_q[i] = '0;
                tag_q[i] = '0;
                rem_set[i] = 1'b0;
            end
            pending.delete();
            errors = 0;
        endfunction

        function void push(logic [1:0] k, logic [3:0] s, logic signed [31:0] r,
                           logic signed [31:0] v, logic l);
            timer_result_t t;
            t.kind = k;
            t.slot = s;
            t.refc = r;
            t.val = v;
            t.last = l;
            pending.push_back(t);
        endfunction

        // note an accepted command and queue the results it causes
        function void note_cmd(timer_cmd_t c);
            int found;
            int n;
            logic signed [31:0] best;
            found = -1;
            n = 0;
            case (c.cmd)
                mcetb_pkg::CMD_ADD:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (found < 0 && st_q[i] == mcetb_pkg::ST_INACTIVE)
                            found = i;
                    if (found < 0)
                        push(mcetb_pkg::KIND_FULL, 4'd0, 32'sd0, 32'sd0, 1'b1);
                    else
                    begin
                        st_q[found] = c.deferred ? mcetb_pkg::ST_DEFERRED
                                                 : mcetb_pkg::ST_ACTIVE;
                        per_q[found] = c.loop;
                        rld_q[found] = {1'b0, c.period};
                        rem_q[found] = clamp32(64'(c.period) + 64'(c.cpu_offset));
                        rem_set[found] = 1'b1;
                        tag_q[found] = c.refcon;
                        push(mcetb_pkg::KIND_DONE, found[3:0], 32'sd0, 32'sd0, 1'b1);
                    end
                end
                mcetb_pkg::CMD_ADJUST:
                begin
                    rem_q[c.slot] = clamp32(64'(c.first_delay) + 64'(c.cpu_offset));
                    rem_set[c.slot] = 1'b1;
                    rld_q[c.slot] = {1'b0, c.period};
                    tag_q[c.slot] = c.refcon;
                    push(mcetb_pkg::KIND_DONE, c.slot, 32'sd0, 32'sd0, 1'b1);
                end
                mcetb_pkg::CMD_REMOVE:
                begin
                    st_q[c.slot] = mcetb_pkg::ST_INACTIVE;
                    push(mcetb_pkg::KIND_DONE, c.slot, 32'sd0, 32'sd0, 1'b1);
                end
                mcetb_pkg::CMD_DEADLINE:
                begin
                    best = {1'b0, c.amount};
                    for (int i = 0; i < SLOTS; i++)
                        if (st_q[i] != mcetb_pkg::ST_INACTIVE && rem_q[i] < best)
                            best = rem_q[i];
                    push(mcetb_pkg::KIND_DONE, 4'd0, 32'sd0, best, 1'b1);
                end
                mcetb_pkg::CMD_ADVANCE:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (st_q[i] != mcetb_pkg::ST_ACTIVE ||
                            rem_q[i] == mcetb_pkg::NEVER_TICKS)
                            continue;
                        rem_q[i] = clamp32(64'(rem_q[i]) - 64'(c.amount));
                        if (rem_q[i] > 0)
                            continue;
                        if (n < FIRE_CAP)
                        begin
                            push(mcetb_pkg::KIND_FIRE, i[3:0], tag_q[i], 32'sd0, 1'b0);
                            n++;
                        end
                        if (!per_q[i])
                            st_q[i] = mcetb_pkg::ST_INACTIVE;
                        else
                        begin
                            if (rld_q[i] <= 0)
                                rld_q[i] = mcetb_pkg::NEVER_TICKS;
                            rem_q[i] = rld_q[i];
                        end
                    end
                    for (int i = 0; i < SLOTS; i++)
                        if (st_q[i] == mcetb_pkg::ST_DEFERRED)
                            st_q[i] = mcetb_pkg::ST_ACTIVE;
                    if (n == 0)
                        push(mcetb_pkg::KIND_DONE, 4'd0, 32'sd0, 32'sd0, 1'b1);
                    else
                        pending[pending.size() - 1].last = 1'b1;
                end
                default:
                    push(mcetb_pkg::KIND_DONE, c.slot, 32'sd0,
                         clamp32(64'(rld_q[c.slot]) - 64'(rem_q[c.slot])), 1'b1);
            endcase
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result kind=%0d slot=%0d", got.kind, got.slot);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind)
            begin
                $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
                errors++;
            end
            if (got.slot !== exp_r.slot)
            begin
                $error("out_slot: expected %0d, got %0d", exp_r.slot, got.slot);
                errors++;
            end
            if (got.refc !== exp_r.refc)
            begin
                $error("out_refcon: expected %0d, got %0d", exp_r.refc, got.refc);
                errors++;
            end
            if (got.val !== exp_r.val)
            begin
                $error("value: expected %0d, got %0d", exp_r.val, got.val);
                errors++;
            end
            if (got.last !== exp_r.last)
            begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    timer_scoreboard sb;
    bit              stall_off;

    multi_channel_event_timer_bank dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [30:0] rand_ticks();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 3));
            1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 200));
        endcase
    endfunction

    function automatic logic [3:0] used_slot();
        int s;
        for (int k = 0; k < 8; k++)
        begin
            s = $urandom_range(0, SLOTS - 1);
            if (sb.rem_set[s])
                return s[3:0];
        end
        for (int i = 0; i < SLOTS; i++)
            if (sb.rem_set[i])
                return i[3:0];
        return 4'd0;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_item(timer_cmd_t c);
        repeat (gap_len()) @(negedge clk);
        s_tdata = {3'b0, c.amount, c.refcon, c.cpu_offset, c.first_delay,
                   c.period, c.deferred, c.loop, c.slot, c.cmd};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_cmd(c);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_fields(logic [2:0] cmd, logic [3:0] slot, logic loop,
                               logic dfr, logic [30:0] period, logic [30:0] fdel,
                               logic [30:0] off, logic signed [31:0] refc,
                               logic [30:0] amt);
        timer_cmd_t c;
        c.cmd = cmd;
        c.slot = slot;
        c.loop = loop;
        c.deferred = dfr;
        c.period = period;
        c.first_delay = fdel;
        c.cpu_offset = off;
        c.refcon = refc;
        c.amount = amt;
        send_item(c);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    // result side: random back-pressure, check on each accepted item
    always @(posedge clk)
    begin
        timer_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.slot = m_tdata[3:0];
            got.refc = m_tdata[35:4];
            got.val = m_tdata[67:36];
            got.last = m_tlast;
            sb.check_result(got);
        end
    end

    initial
    begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!stall_off && $urandom_range(0, 3) == 0)
            begin
                hold = gap_len();
                m_tready <= (hold == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        timer_cmd_t c;
        int r;
        sb = new();
        sb.clear();
        stall_off = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fill the table, overflow it, extremes, saturation
        send_fields(mcetb_pkg::CMD_DEADLINE, 4'd0, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0,
                    32'sd0, 31'h7FFF_FFFF);
        send_fields(mcetb_pkg::CMD_ADVANCE, 4'd0, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0,
                    32'sd0, 31'd5);
        for (int i = 0; i < SLOTS; i++)
            send_fields(mcetb_pkg::CMD_ADD, 4'd0, i[0], i == 3, 31'(i * 3), 31'd0,
                        (i == 15) ? 31'h7FFF_FFFF : 31'd1,
                        (i == 0) ? INT_MIN : 32'(32'sh7FFF_FFFF - i), 31'd0);
        send_fields(mcetb_pkg::CMD_ADD, 4'd0, 1'b1, 1'b1, 31'h7FFF_FFFF, 31'd0, 31'd0,
                    -32'sd1, 31'd0);
        send_fields(mcetb_pkg::CMD_ELAPSED, 4'd15, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0,
                    32'sd0, 31'd0);
        send_fields(mcetb_pkg::CMD_DEADLINE, 4'd0, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0,
                    32'sd0, 31'd1000);
        send_fields(mcetb_pkg::CMD_ADVANCE, 4'd0, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0,
                    32'sd0, 31'h7FFF_FFFF);
        send_fields(mcetb_pkg::CMD_ADJUST, 4'd15, 1'b0, 1'b0, 31'h7FFF_FFFF,
                    31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh1234_5678, 31'd0);
        send_fields(mcetb_pkg::CMD_ELAPSED, 4'd15, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0,
                    32'sd0, 31'd0);
        send_fields(mcetb_pkg::CMD_REMOVE, 4'd15, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0,
                    32'sd0, 31'd0);
        send_fields(mcetb_pkg::CMD_ADVANCE, 4'd0, 1'b0, 1'b0, 31'd0, 31'd0, 31'd0,
                    32'sd0, 31'd0);

        // hold off the sender until the bank has answered everything
        wait_drained();

        for (int k = 0; k < 355; k++)
        begin
            stall_off = (k >= 150 && k < 190);
            r = $urandom_range(0, 99);
            c.slot = 4'($urandom);
            c.loop = 1'($urandom);
            c.deferred = ($urandom_range(0, 3) == 0);
            c.period = rand_ticks();
            c.first_delay = rand_ticks();
            c.cpu_offset = ($urandom_range(0, 2) == 0) ? rand_ticks()
                                                        : 31'($urandom_range(0, 20));
            c.refcon = $urandom;
            c.amount = rand_ticks();
            if (r < 30)
                c.cmd = mcetb_pkg::CMD_ADD;
            else if (r < 42)
            begin
                c.cmd = mcetb_pkg::CMD_ADJUST;
            end
            else if (r < 52)
                c.cmd = mcetb_pkg::CMD_REMOVE;
            else if (r < 62)
                c.cmd = mcetb_pkg::CMD_DEADLINE;
            else if (r < 88)
            begin
                c.cmd = mcetb_pkg::CMD_ADVANCE;
                if ($urandom_range(0, 3) != 0)
                    c.amount = 31'($urandom_range(1, 150));
            end
            else
            begin
                c.cmd = mcetb_pkg::CMD_ELAPSED;
                c.slot = used_slot();
            end
            send_item(c);
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/mcetb_pkg.sv
rtl/mcetb_datapath.sv
rtl/mcetb_ctrl.sv
rtl/multi_channel_event_timer_bank.sv
test/multi_channel_event_timer_bank_tb.sv
